>>> hdl/vector3_alu_unit_macros.svh
// Assertion macros for the vector ALU.
`ifndef VECTOR3_ALU_UNIT_MACROS_SVH
`define VECTOR3_ALU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define V3A_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define V3A_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define V3A_ASSERT_IMPL(label, clk, rst_n, prop)
`define V3A_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> hdl/v3alu_pkg.sv
// Types, codes and constants for the vector ALU.
`default_nettype none
package v3alu_pkg;
	typedef enum logic [2:0] {
		FN_ADD = 3'd0, FN_SUB = 3'd1, FN_SCALE = 3'd2,
		FN_DOT = 3'd3, FN_MAG = 3'd4, FN_NORM = 3'd5
	} func_t;

	typedef struct packed {
		logic [2:0] func;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] factor;
	} req_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] rscalar;
		logic zero_vector;
		logic overflow;
	} rsp_t;

	localparam int SQ_W = 66;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

>>> hdl/vector3_alu_unit.sv
// Pipelined three-component fixed-point vector ALU.
//  channel  | signals                 | handshake
//  request  | start, busy, req        | taken when start && !busy
//  result   | done, rsp               | one-cycle strobe, cannot stall
// One request per cycle; busy stays low. done rises after these registers, in
// order: stage 1 squares/products, stage 2 sums and rounds, 33 square root
// stages (one root bit each), a root rounding stage, a pipelined restoring
// divider (FRAC_BITS+33 stages, all three lanes), then the output register.
// arst_n clears all valid bits; payload registers are not reset.
`default_nettype none
`include "vector3_alu_unit_macros.svh"
module vector3_alu_unit import v3alu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t req,
	output logic done,
	output rsp_t rsp
);
	localparam int RW = 33;                  // sqrt result width
	localparam int NW = 32 + FRAC_BITS;      // dividend width is NW+1 bits
	localparam int DSTG = NW + 1;            // divider stages
	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

	typedef struct packed {
		logic [2:0] func;
		logic signed [31:0] ax, ay, az;
		logic [31:0] vx, vy, vz;      // add/sub/scale result
		logic [2:0] ovv;
		logic signed [31:0] dot;
		logic ovd;
		logic [SQ_W-1:0] s;           // sum of squares
	} mid_t;

	assign busy = 1'b0;

	function automatic logic signed [31:0] sat(input logic signed [67:0] v, output logic o);
		begin
			o = 1'b0;
			if (v > 68'sd2147483647) begin o = 1'b1; sat = S32_MAX; end
			else if (v < -68'sd2147483648) begin o = 1'b1; sat = S32_MIN; end
			else sat = v[31:0];
		end
	endfunction

	// stage 1: products and add/sub sums
	logic v_s1;
	req_t r_s1;
	logic signed [63:0] pa_s1 [3];
	logic signed [63:0] pq_s1 [3];
	logic signed [32:0] as_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		r_s1 <= req;
		pa_s1[0] <= (req.func == FN_SCALE) ? req.ax * req.factor : req.ax * req.bx;
		pa_s1[1] <= (req.func == FN_SCALE) ? req.ay * req.factor : req.ay * req.by;
		pa_s1[2] <= (req.func == FN_SCALE) ? req.az * req.factor : req.az * req.bz;
		pq_s1[0] <= req.ax * req.ax;
		pq_s1[1] <= req.ay * req.ay;
		pq_s1[2] <= req.az * req.az;
		as_s1[0] <= (req.func == FN_SUB) ? 33'(req.ax) - 33'(req.bx) : 33'(req.ax) + 33'(req.bx);
		as_s1[1] <= (req.func == FN_SUB) ? 33'(req.ay) - 33'(req.by) : 33'(req.ay) + 33'(req.by);
		as_s1[2] <= (req.func == FN_SUB) ? 33'(req.az) - 33'(req.bz) : 33'(req.az) + 33'(req.bz);
	end

	// stage 2: sums, rounding, saturation
	logic v_s2;
	mid_t m_s2;
	mid_t m_c;
	always_comb begin
		logic signed [67:0] t;
		logic o;
		m_c = '0;
		m_c.func = r_s1.func;
		m_c.ax = r_s1.ax; m_c.ay = r_s1.ay; m_c.az = r_s1.az;
		for (int i = 0; i < 3; i++) begin
			if (r_s1.func == FN_SCALE) t = (68'(pa_s1[i]) + 68'(HALF)) >>> FRAC_BITS;
			else t = 68'(as_s1[i]);
			case (i)
				0: m_c.vx = sat(t, o);
				1: m_c.vy = sat(t, o);
				default: m_c.vz = sat(t, o);
			endcase
			m_c.ovv[i] = o;
		end
		t = (68'(pa_s1[0]) + 68'(pa_s1[1]) + 68'(pa_s1[2]) + 68'(HALF)) >>> FRAC_BITS;
		m_c.dot = sat(t, o);
		m_c.ovd = o;
		m_c.s = SQ_W'(pq_s1[0]) + SQ_W'(pq_s1[1]) + SQ_W'(pq_s1[2]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) m_s2 <= m_c;

	// square root pipeline: one result bit per stage, MSB first
	logic v_q [RW+1];
	mid_t m_q [RW+1];
	logic [SQ_W:0] rem_q [RW+1];
	logic [RW-1:0] root_q [RW+1];
	assign v_q[0] = v_s2;
	assign m_q[0] = m_s2;
	assign rem_q[0] = '0;
	assign root_q[0] = '0;
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [SQ_W:0] tr, tt;
		always_comb begin
			tr = {rem_q[k][SQ_W-2:0], m_q[k].s[SQ_W-1-2*k -: 2]};
			tt = {(SQ_W-RW-1)'(0), root_q[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			m_q[k+1] <= m_q[k];
			if (tr >= tt) begin
				rem_q[k+1] <= tr - tt;
				root_q[k+1] <= {root_q[k][RW-2:0], 1'b1};
			end else begin
				rem_q[k+1] <= tr;
				root_q[k+1] <= {root_q[k][RW-2:0], 1'b0};
			end
		end
	end

	// round: remainder > root means round up
	logic v_r;
	mid_t m_r;
	logic [RW:0] mag_r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_r <= 1'b0;
		else v_r <= v_q[RW];
	end
	always_ff @(posedge clk) begin
		m_r <= m_q[RW];
		mag_r <= (rem_q[RW] > (SQ_W+1)'(root_q[RW])) ? {1'b0, root_q[RW]} + 1'b1
			: {1'b0, root_q[RW]};
	end

	// divider: q = (2*|c|*2^F + m) / (2m), one quotient bit per stage
	localparam int DW = RW + 2;
	logic dv [DSTG+1];
	mid_t dm [DSTG+1];
	logic [RW:0] dmag [DSTG+1];
	logic [NW:0] dn [DSTG+1][3];
	logic [DW:0] dr [DSTG+1][3];
	logic [NW:0] dq [DSTG+1][3];
	assign dv[0] = v_r;
	assign dm[0] = m_r;
	assign dmag[0] = mag_r;
	for (genvar l = 0; l < 3; l++) begin : g_din
		logic [31:0] c;
		logic [31:0] ac;
		assign c = (l == 0) ? m_r.ax : (l == 1) ? m_r.ay : m_r.az;
		assign ac = c[31] ? (~c + 1'b1) : c;
		// numerator (2*num + m) >> handled as: floor((num + m/2)/m)
		// compute 2num+m over 2m: dividend 2num, divisor 2m, m folded in at the end
		assign dn[0][l] = {ac, FRAC_BITS'(0), 1'b0};
		assign dr[0][l] = '0;
		assign dq[0][l] = '0;
	end
	for (genvar k = 0; k <= DSTG; k++) begin : g_div
		if (k < DSTG) begin : g_st
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dv[k+1] <= 1'b0;
				else dv[k+1] <= dv[k];
			end
			always_ff @(posedge clk) begin
				dm[k+1] <= dm[k];
				dmag[k+1] <= dmag[k];
			end
			for (genvar l = 0; l < 3; l++) begin : g_ln
				logic [DW:0] tr;
				logic [DW:0] dd;
				always_comb begin
					dd = {1'b0, dmag[k], 1'b0};
					tr = {dr[k][l][DW-1:0], dn[k][l][NW]};
				end
				always_ff @(posedge clk) begin
					dn[k+1][l] <= {dn[k][l][NW-1:0], 1'b0};
					if (tr >= dd) begin
						dr[k+1][l] <= tr - dd;
						dq[k+1][l] <= {dq[k][l][NW-1:0], 1'b1};
					end else begin
						dr[k+1][l] <= tr;
						dq[k+1][l] <= {dq[k][l][NW-1:0], 1'b0};
					end
				end
			end
		end
	end

	// last step folds the rounding term: remainder + m vs 2m
	rsp_t out_c;
	always_comb begin
		logic [DW+1:0] fr;
		logic [NW+1:0] q;
		logic signed [67:0] sv;
		logic [31:0] c;
		logic o;
		out_c = '0;
		case (func_t'(dm[DSTG].func))
			FN_ADD, FN_SUB, FN_SCALE: begin
				out_c.rx = dm[DSTG].vx; out_c.ry = dm[DSTG].vy; out_c.rz = dm[DSTG].vz;
				out_c.overflow = |dm[DSTG].ovv;
			end
			FN_DOT: begin
				out_c.rscalar = dm[DSTG].dot;
				out_c.overflow = dm[DSTG].ovd;
			end
			FN_MAG: begin
				out_c.rscalar = dmag[DSTG][RW] ? S32_MAX
					: (dmag[DSTG][31] ? S32_MAX : 32'(dmag[DSTG]));
				out_c.overflow = dmag[DSTG][RW] | dmag[DSTG][31];
			end
			FN_NORM: begin
				if (dm[DSTG].s == '0) out_c.zero_vector = 1'b1;
				else begin
					for (int l = 0; l < 3; l++) begin
						c = (l == 0) ? dm[DSTG].ax : (l == 1) ? dm[DSTG].ay : dm[DSTG].az;
						// quotient of 2num/(2m) plus round if 2rem + ... : use rem vs m
						fr = {1'b0, dr[DSTG][l]};
						q = {1'b0, dq[DSTG][l]} + ((fr + (DW+2)'(dmag[DSTG])) >=
							(DW+2)'({dmag[DSTG], 1'b0}) ? 1'b1 : 1'b0);
						sv = c[31] ? -68'(q) : 68'(q);
						case (l)
							0: out_c.rx = sat(sv, o);
							1: out_c.ry = sat(sv, o);
							default: out_c.rz = sat(sv, o);
						endcase
						out_c.overflow = out_c.overflow | o;
					end
				end
			end
			default: out_c = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv[DSTG];
	end
	always_ff @(posedge clk) rsp <= out_c;

	`V3A_ASSERT_NEVER(a_busy_low, clk, arst_n, busy)
	`V3A_ASSERT_IMPL(a_zv_norm, clk, arst_n, done && rsp.zero_vector |-> rsp.rx == 32'sd0 && rsp.ry == 32'sd0)
	`V3A_ASSERT_IMPL(a_s2_follows, clk, arst_n, v_s1 |=> v_s2)
endmodule
`default_nettype wire

>>> tb/vector3_alu_checker.sv
// Checker for the vector ALU: predicts each request's result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module vector3_alu_checker import v3alu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t req,
	input wire logic done,
	input wire rsp_t rsp,
	output int fails,
	output int pending
);
	localparam int FRAC = 16;
	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC - 1);

	rsp_t result_q[$];

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic logic signed [31:0] clamp32(input logic signed [66:0] v, inout bit ov);
		if (v > 67'sh7FFF_FFFF) begin
			ov = 1'b1;
			return S32_MAX;
		end
		if (v < -67'sh8000_0000) begin
			ov = 1'b1;
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	// integer square root, rounded to nearest
	function automatic logic [66:0] round_root(input logic [66:0] s);
		logic [66:0] r;
		logic [66:0] t;
		r = '0;
		for (int i = 33; i >= 0; i--) begin
			t = r | (67'd1 << i);
			if (t * t <= s)
				r = t;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	function automatic rsp_t vector_result(input req_t q);
		logic signed [66:0] av[3];
		logic signed [66:0] bv[3];
		logic signed [66:0] fv;
		logic signed [66:0] acc;
		logic [66:0] ssum;
		logic [66:0] root;
		logic [66:0] num;
		logic [66:0] quo;
		logic signed [31:0] vec[3];
		bit ov;
		rsp_t r;
		av[0] = q.ax;
		av[1] = q.ay;
		av[2] = q.az;
		bv[0] = q.bx;
		bv[1] = q.by;
		bv[2] = q.bz;
		fv = q.factor;
		r = '0;
		ov = 1'b0;
		vec[0] = '0;
		vec[1] = '0;
		vec[2] = '0;
		ssum = $unsigned(av[0] * av[0] + av[1] * av[1] + av[2] * av[2]);
		root = round_root(ssum);
		case (q.func)
			FN_ADD: begin
				for (int i = 0; i < 3; i++)
					vec[i] = clamp32(av[i] + bv[i], ov);
			end
			FN_SUB: begin
				for (int i = 0; i < 3; i++)
					vec[i] = clamp32(av[i] - bv[i], ov);
			end
			FN_SCALE: begin
				// round half toward plus infinity
				for (int i = 0; i < 3; i++)
					vec[i] = clamp32((av[i] * fv + HALF) >>> FRAC, ov);
			end
			FN_DOT: begin
				acc = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
				r.rscalar = clamp32((acc + HALF) >>> FRAC, ov);
			end
			FN_MAG: r.rscalar = clamp32($signed(root), ov);
			FN_NORM: begin
				if (ssum == 0) begin
					r.zero_vector = 1'b1;
				end else begin
					// half away from zero on the magnitude, sign restored after
					for (int i = 0; i < 3; i++) begin
						num = $unsigned(av[i] < 0 ? -av[i] : av[i]) << FRAC;
						quo = (2 * num + root) / (2 * root);
						vec[i] = clamp32(av[i] < 0 ? -$signed(quo) : $signed(quo), ov);
					end
				end
			end
			default: ;
		endcase
		r.rx = vec[0];
		r.ry = vec[1];
		r.rz = vec[2];
		r.overflow = ov;
		return r;
	endfunction

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
		fails++;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (start && !busy)
				result_q.push_back(vector_result(req));
			if (done) begin
				if (result_q.size() == 0) begin
					report("unexpected result", rsp.rscalar, '0);
				end else begin
					want = result_q.pop_front();
					if (rsp.rx !== want.rx)
						report("rx", rsp.rx, want.rx);
					if (rsp.ry !== want.ry)
						report("ry", rsp.ry, want.ry);
					if (rsp.rz !== want.rz)
						report("rz", rsp.rz, want.rz);
					if (rsp.rscalar !== want.rscalar)
						report("rscalar", rsp.rscalar, want.rscalar);
					if (rsp.zero_vector !== want.zero_vector)
						report("zero_vector", rsp.zero_vector, want.zero_vector);
					if (rsp.overflow !== want.overflow)
						report("overflow", rsp.overflow, want.overflow);
				end
			end
			pending = result_q.size();
		end
	end
endmodule
`default_nettype wire

>>> tb/tb_vector3_alu_unit.sv
// Top of the vector ALU testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_vector3_alu_unit;
	import v3alu_pkg::*;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam int DRAIN_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int fails;
	int pending;

	always #2 clk = ~clk;

	vector3_alu_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	vector3_alu_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.fails(fails),
		.pending(pending)
	);

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			3: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
			4: begin
				case ($urandom_range(0, 4))
					0: return S32_MAX;
					1: return S32_MIN;
					2: return 32'h0001_0000;
					3: return 32'hFFFF_0000;
					default: return '0;
				endcase
			end
			default: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
		endcase
	endfunction

	// issue one request and hold it until taken, then an optional gap
	task automatic issue(input logic [2:0] f, input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [31:0] bx, input logic [31:0] by,
			input logic [31:0] bz, input logic [31:0] fac, input bit gaps);
		int gap;
		start <= 1'b1;
		req <= '{func: f, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, factor: fac};
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		gap = gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [2:0] f;
		bit gaps;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FN_ADD, S32_MAX, S32_MIN, 32'h0001_8000, S32_MAX, S32_MIN, 32'hFFFF_0000, 0, 1'b0);
		issue(FN_SUB, S32_MIN, S32_MAX, 32'h0000_0001, S32_MAX, S32_MIN, 32'h0000_0001, 0, 1'b1);
		issue(FN_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, S32_MAX, 0, 0, 0, 32'h0000_8000, 1'b0);
		issue(FN_SCALE, S32_MIN, S32_MAX, 32'h0003_0000, 0, 0, 0, S32_MIN, 1'b1);
		issue(FN_SCALE, 32'h0002_0000, 32'hFFFE_0000, 0, 0, 0, 0, 32'h0001_8000, 1'b0);
		issue(FN_DOT, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 0, 1'b0);
		issue(FN_DOT, S32_MAX, S32_MIN, 32'h0000_8000, S32_MIN, S32_MAX, 32'h0000_0001, 0, 1'b1);
		issue(FN_DOT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 0, 1'b0);
		issue(FN_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 1'b0);
		issue(FN_MAG, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0, 1'b1);
		issue(FN_MAG, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		issue(FN_MAG, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 0, 0, 1'b0);
		// normalize of an all-zero vector raises the flag
		issue(FN_NORM, 0, 0, 0, S32_MAX, S32_MIN, 32'h1234_5678, S32_MAX, 1'b1);
		issue(FN_NORM, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 1'b0);
		issue(FN_NORM, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0);
		issue(FN_NORM, S32_MIN, S32_MAX, S32_MIN, 0, 0, 0, 0, 1'b1);
		issue(FN_NORM, 32'h0000_0003, 32'hFFFF_FFFC, 0, 0, 0, 0, 0, 1'b0);
		issue(FN_SPARE6, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1'b0);
		issue(FN_SPARE7, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1'b1);

		for (int n = 0; n < 880; n++) begin
			// long back-to-back stretches alternate with gappy ones
			gaps = ((n / 100) % 2) == 1;
			f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
			issue(f, pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value(), gaps);
			if (n == 440) begin
				start <= 1'b0;
				wait_drained();
			end
		end
		start <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

>>> vector3_alu_unit.f
+incdir+hdl
hdl/v3alu_pkg.sv
hdl/vector3_alu_unit.sv
tb/vector3_alu_checker.sv
tb/tb_vector3_alu_unit.sv
